@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, count codes and job types shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// coefficient and fixed point format
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int ROOT_W    = 40;

	// discriminant magnitude, radicand and square root widths
	localparam int DISC_W = 2 * COEF_W + 1;
	localparam int DS_W   = 2 * COEF_W + 3;
	localparam int RAD_W  = DISC_W + 2 * FRAC_BITS;
	localparam int SQ_W   = (RAD_W + 1) / 2;

	// scaled -b or -c, numerators, magnitudes and denominators
	localparam int NB_W   = COEF_W + 1 + FRAC_BITS;
	localparam int NUM_W  = ((NB_W > SQ_W + 1) ? NB_W : SQ_W + 1) + 1;
	localparam int MAG_W  = NUM_W;
	localparam int DEN_W  = COEF_W + 2;
	localparam int DMAG_W = DEN_W - 1;

	// queue between classifier and solver
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// root count codes
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;
	localparam logic [1:0] CNT_ALL  = 2'd3;

	// classified job handed from the front to the solver
	typedef struct packed {
		logic [1:0]              cnt;
		logic                    sq;
		logic signed [NB_W-1:0]  nb;
		logic signed [DEN_W-1:0] den;
		logic [DISC_W-1:0]       disc;
	} job_t;

	// tag that follows a job through the divider
	typedef struct packed {
		logic [1:0] cnt;
		logic       sq;
	} tag_t;

endpackage

@@ rtl/qrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient items, forms the discriminant and classifies each item
// into a job: root count, scaled numerator base, denominator and discriminant.
// ----------------------------------------------------------------------------
module qrs_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [qrs_pkg::COEF_W-1:0]   coef_a,
	input  logic signed [qrs_pkg::COEF_W-1:0]   coef_b,
	input  logic signed [qrs_pkg::COEF_W-1:0]   coef_c,
	output logic                                out_valid,
	output qrs_pkg::job_t                       out_job
);

	localparam int W = qrs_pkg::COEF_W;

	logic                           v_s1;
	logic signed [W-1:0]            a_s1, b_s1, c_s1;
	logic signed [2*W-1:0]          bb_s1, ac_s1;
	logic                           v_s2;
	qrs_pkg::job_t                  job_s2;
	qrs_pkg::job_t                  job_d;

	logic signed [qrs_pkg::DS_W-1:0]  dsum;
	logic signed [qrs_pkg::NB_W-1:0]  nb_b, nb_c;
	logic signed [qrs_pkg::DEN_W-1:0] a_ext, b_ext, abs_a;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			c_s1  <= coef_c;
			bb_s1 <= coef_b * coef_b;
			ac_s1 <= coef_a * coef_c;
		end
	end

	// discriminant and scaled operands
	assign dsum  = qrs_pkg::DS_W'(bb_s1) - (qrs_pkg::DS_W'(ac_s1) <<< 2);
	assign nb_b  = -(qrs_pkg::NB_W'(b_s1) <<< qrs_pkg::FRAC_BITS);
	assign nb_c  = -(qrs_pkg::NB_W'(c_s1) <<< qrs_pkg::FRAC_BITS);
	assign a_ext = qrs_pkg::DEN_W'(a_s1);
	assign b_ext = qrs_pkg::DEN_W'(b_s1);
	assign abs_a = a_s1[W-1] ? -a_ext : a_ext;

	// classification of the degenerate and general cases
	always_comb begin
		job_d = '0;
		if (a_s1 == '0) begin
			if (b_s1 == '0) begin
				job_d.cnt = (c_s1 == '0) ? qrs_pkg::CNT_ALL : qrs_pkg::CNT_NONE;
			end else begin
				job_d.cnt = qrs_pkg::CNT_ONE;
				job_d.nb  = nb_c;
				job_d.den = b_ext;
			end
		end else if (c_s1 == '0 && b_s1 != '0) begin
			job_d.cnt = qrs_pkg::CNT_TWO;
			job_d.nb  = nb_b;
			job_d.den = a_ext;
		end else begin
			job_d.nb  = nb_b;
			job_d.den = (b_s1 == '0) ? (abs_a <<< 1) : (a_ext <<< 1);
			if (dsum < 0) begin
				job_d.cnt = qrs_pkg::CNT_NONE;
			end else if (dsum == '0) begin
				job_d.cnt = qrs_pkg::CNT_ONE;
			end else begin
				job_d.cnt  = qrs_pkg::CNT_TWO;
				job_d.sq   = 1'b1;
				job_d.disc = dsum[qrs_pkg::DISC_W-1:0];
			end
		end
	end

	// stage 2: classified job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s2 <= job_d;
		end
	end

	assign out_valid = v_s2;
	assign out_job   = job_s2;

endmodule

@@ rtl/qrs_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_fifo
// Short job queue that decouples the classifier from the solver pipeline.
// ----------------------------------------------------------------------------
module qrs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qrs_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output qrs_pkg::job_t head_job
);

	localparam int AW = qrs_pkg::FIFO_AW;

	qrs_pkg::job_t   mem_q [qrs_pkg::FIFO_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;

	assign full      = (count_q == (AW+1)'(qrs_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(qrs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(qrs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue never overruns or underruns
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("job queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(qrs_pkg::FIFO_DEPTH)) else $error("job queue count out of range");

endmodule

@@ rtl/qrs_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit square root of the scaled discriminant, one root
// bit per stage, carrying the job alongside.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  qrs_pkg::job_t                in_job,
	output logic                         out_valid,
	output qrs_pkg::job_t                out_job,
	output logic [qrs_pkg::SQ_W-1:0]     root,
	output logic                         inexact
);

	localparam int N     = qrs_pkg::SQ_W;
	localparam int R2    = 2 * N;
	localparam int REM_W = N + 2;

	logic                 v_q    [N];
	qrs_pkg::job_t        job_q  [N];
	logic [R2-1:0]        rad_q  [N];
	logic [REM_W-1:0]     rem_q  [N];
	logic [N-1:0]         root_q [N];

	logic [R2-1:0] rad_in;

	assign rad_in = R2'(in_job.disc) << (2 * qrs_pkg::FRAC_BITS);

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic                v_i;
			qrs_pkg::job_t       job_i;
			logic [R2-1:0]       rad_i;
			logic [REM_W-1:0]    rem_i, rem_sh, trial;
			logic [N-1:0]        root_i;
			logic                ge;

			if (k == 0) begin : g_first
				assign v_i    = in_valid;
				assign job_i  = in_job;
				assign rad_i  = rad_in;
				assign rem_i  = '0;
				assign root_i = '0;
			end else begin : g_next
				assign v_i    = v_q[k-1];
				assign job_i  = job_q[k-1];
				assign rad_i  = rad_q[k-1];
				assign rem_i  = rem_q[k-1];
				assign root_i = root_q[k-1];
			end

			// trial subtract of the next root bit
			assign rem_sh = {rem_i[REM_W-3:0], rad_i[R2-1 -: 2]};
			assign trial  = {root_i, 2'b01};
			assign ge     = (rem_sh >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en) begin
					v_q[k] <= v_i;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					job_q[k]  <= job_i;
					rad_q[k]  <= rad_i << 2;
					rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
					root_q[k] <= {root_i[N-2:0], ge};
				end
			end
		end
	endgenerate

	assign out_valid = v_q[N-1];
	assign out_job   = job_q[N-1];
	assign root      = root_q[N-1];
	assign inexact   = (rem_q[N-1] != '0);

endmodule

@@ rtl/qrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider, one quotient bit per stage, for the
// first and second root magnitudes over a shared denominator.
// ----------------------------------------------------------------------------
module qrs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  qrs_pkg::tag_t                 in_tag,
	input  logic [qrs_pkg::MAG_W-1:0]     num1,
	input  logic [qrs_pkg::MAG_W-1:0]     num2,
	input  logic                          neg1,
	input  logic                          neg2,
	input  logic [qrs_pkg::DMAG_W-1:0]    dmag,
	output logic                          out_valid,
	output qrs_pkg::tag_t                 out_tag,
	output logic [qrs_pkg::MAG_W-1:0]     quo1,
	output logic [qrs_pkg::MAG_W-1:0]     quo2,
	output logic                          out_neg1,
	output logic                          out_neg2
);

	localparam int N  = qrs_pkg::MAG_W;
	localparam int DW = qrs_pkg::DMAG_W;

	logic              v_q    [N];
	qrs_pkg::tag_t     tag_q  [N];
	logic [1:0]        neg_q  [N];
	logic [DW-1:0]     d_q    [N];
	logic [N-1:0]      n1_q   [N];
	logic [N-1:0]      n2_q   [N];
	logic [DW-1:0]     r1_q   [N];
	logic [DW-1:0]     r2_q   [N];
	logic [N-1:0]      q1_q   [N];
	logic [N-1:0]      q2_q   [N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic              v_i;
			qrs_pkg::tag_t     tag_i;
			logic [1:0]        neg_i;
			logic [DW-1:0]     d_i, r1_i, r2_i;
			logic [N-1:0]      n1_i, n2_i, q1_i, q2_i;
			logic [DW:0]       sh1, sh2;
			logic              ge1, ge2;

			if (k == 0) begin : g_first
				assign v_i   = in_valid;
				assign tag_i = in_tag;
				assign neg_i = {neg2, neg1};
				assign d_i   = dmag;
				assign n1_i  = num1;
				assign n2_i  = num2;
				assign r1_i  = '0;
				assign r2_i  = '0;
				assign q1_i  = '0;
				assign q2_i  = '0;
			end else begin : g_next
				assign v_i   = v_q[k-1];
				assign tag_i = tag_q[k-1];
				assign neg_i = neg_q[k-1];
				assign d_i   = d_q[k-1];
				assign n1_i  = n1_q[k-1];
				assign n2_i  = n2_q[k-1];
				assign r1_i  = r1_q[k-1];
				assign r2_i  = r2_q[k-1];
				assign q1_i  = q1_q[k-1];
				assign q2_i  = q2_q[k-1];
			end

			// shift in the next numerator bit and try the subtract
			assign sh1 = {r1_i, n1_i[N-1]};
			assign sh2 = {r2_i, n2_i[N-1]};
			assign ge1 = (sh1 >= {1'b0, d_i});
			assign ge2 = (sh2 >= {1'b0, d_i});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en) begin
					v_q[k] <= v_i;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					tag_q[k] <= tag_i;
					neg_q[k] <= neg_i;
					d_q[k]   <= d_i;
					n1_q[k]  <= n1_i << 1;
					n2_q[k]  <= n2_i << 1;
					r1_q[k]  <= ge1 ? DW'(sh1 - {1'b0, d_i}) : DW'(sh1);
					r2_q[k]  <= ge2 ? DW'(sh2 - {1'b0, d_i}) : DW'(sh2);
					q1_q[k]  <= {q1_i[N-2:0], ge1};
					q2_q[k]  <= {q2_i[N-2:0], ge2};
				end
			end
		end
	endgenerate

	assign out_valid = v_q[N-1];
	assign out_tag   = tag_q[N-1];
	assign quo1      = q1_q[N-1];
	assign quo2      = q2_q[N-1];
	assign out_neg1  = neg_q[N-1][0];
	assign out_neg2  = neg_q[N-1][1];

endmodule

@@ rtl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// throughput: one item per cycle when the output does not stall; the solver
// pipeline moves one stage per cycle while the output is not stalled
// the depth is set by one square root bit and one quotient bit per stage
// a four-entry job queue lets the classifier run on while the solver stalls
// reset: arst_n clears all valid flags and the queue; no data is cleared
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c=0 in signed Q24.16, rounded toward zero, with a
// root count code.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // root_count [1:0], first_root [41:2], second_root [81:42]
);

	localparam int W     = qrs_pkg::COEF_W;
	localparam int RW    = qrs_pkg::ROOT_W;
	localparam int MW    = qrs_pkg::MAG_W;
	localparam int NW    = qrs_pkg::NUM_W;
	localparam int EXT_W = ((MW + 1 > RW) ? MW + 1 : RW) + 1;
	localparam logic signed [EXT_W-1:0] RMAX = EXT_W'({(RW-1){1'b1}});
	localparam logic signed [EXT_W-1:0] RMIN = -RMAX - 1;

	// clamp a signed quotient to the root range
	function automatic logic [RW-1:0] sat_root(input logic signed [MW:0] v);
		logic signed [EXT_W-1:0] x;
		x = EXT_W'(v);
		if (x > RMAX) begin
			x = RMAX;
		end else if (x < RMIN) begin
			x = RMIN;
		end
		return x[RW-1:0];
	endfunction

	logic          en_f, en_b;
	logic          f_valid;
	qrs_pkg::job_t f_job;
	logic          q_full, q_nempty;
	qrs_pkg::job_t q_job;

	logic                      sq_valid, sq_inexact;
	qrs_pkg::job_t             sq_job;
	logic [qrs_pkg::SQ_W-1:0]  sq_root;

	logic signed [NW-1:0]      nbx, sx, n1, n2;
	logic                      inex;
	logic [MW-1:0]             mag1, mag2;
	logic signed [qrs_pkg::DEN_W-1:0] den;
	logic [qrs_pkg::DEN_W-1:0] den_abs;

	logic                          v_s1;
	qrs_pkg::tag_t                 tag_s1;
	logic [MW-1:0]                 mag1_s1, mag2_s1;
	logic                          neg1_s1, neg2_s1;
	logic [qrs_pkg::DMAG_W-1:0]    dmag_s1;

	logic                 dv_valid, dv_neg1, dv_neg2;
	qrs_pkg::tag_t        dv_tag;
	logic [MW-1:0]        dv_q1, dv_q2;
	logic signed [MW:0]   qs1, qs2;

	logic                 out_v_q;
	logic [1:0]           cnt_q;
	logic [RW-1:0]        r1_q, r2_q;

	// stall control: front waits on the queue, back waits on the output
	assign en_f     = !f_valid || !q_full;
	assign en_b     = !out_v_q || m_tready;
	assign s_tready = en_f;

	// front: classification
	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (s_tvalid),
		.coef_a    (s_tdata[W-1:0]),
		.coef_b    (s_tdata[2*W-1:W]),
		.coef_c    (s_tdata[3*W-1:2*W]),
		.out_valid (f_valid),
		.out_job   (f_job)
	);

	// job queue
	qrs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid && !q_full),
		.push_job  (f_job),
		.pop       (en_b && q_nempty),
		.full      (q_full),
		.not_empty (q_nempty),
		.head_job  (q_job)
	);

	// back: square root of the discriminant
	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (q_nempty),
		.in_job    (q_job),
		.out_valid (sq_valid),
		.out_job   (sq_job),
		.root      (sq_root),
		.inexact   (sq_inexact)
	);

	// numerators and sign-magnitude operands for the divider
	assign nbx  = NW'(sq_job.nb);
	assign sx   = NW'(sq_root);
	assign inex = sq_job.sq && sq_inexact;
	assign n1   = sq_job.sq ? nbx + sx : nbx;
	assign n2   = sq_job.sq ? (inex ? nbx - sx - NW'(1) : nbx - sx) : '0;
	assign mag1 = n1[NW-1] ? (inex ? ~n1 : -n1) : n1;
	assign mag2 = n2[NW-1] ? (inex ? ~n2 : -n2) : n2;
	assign den  = sq_job.den;
	assign den_abs = den[qrs_pkg::DEN_W-1] ? -den : den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_b) begin
			v_s1 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			tag_s1.cnt <= sq_job.cnt;
			tag_s1.sq  <= sq_job.sq;
			mag1_s1    <= mag1;
			mag2_s1    <= mag2;
			neg1_s1    <= n1[NW-1] ^ den[qrs_pkg::DEN_W-1];
			neg2_s1    <= n2[NW-1] ^ den[qrs_pkg::DEN_W-1];
			dmag_s1    <= den_abs[qrs_pkg::DMAG_W-1:0];
		end
	end

	// back: divider
	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (v_s1),
		.in_tag    (tag_s1),
		.num1      (mag1_s1),
		.num2      (mag2_s1),
		.neg1      (neg1_s1),
		.neg2      (neg2_s1),
		.dmag      (dmag_s1),
		.out_valid (dv_valid),
		.out_tag   (dv_tag),
		.quo1      (dv_q1),
		.quo2      (dv_q2),
		.out_neg1  (dv_neg1),
		.out_neg2  (dv_neg2)
	);

	assign qs1 = dv_neg1 ? -$signed({1'b0, dv_q1}) : $signed({1'b0, dv_q1});
	assign qs2 = dv_neg2 ? -$signed({1'b0, dv_q2}) : $signed({1'b0, dv_q2});

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_b) begin
			out_v_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			cnt_q <= dv_tag.cnt;
			r1_q  <= (dv_tag.cnt == qrs_pkg::CNT_ONE || dv_tag.cnt == qrs_pkg::CNT_TWO)
				? sat_root(qs1) : '0;
			r2_q  <= (dv_tag.cnt == qrs_pkg::CNT_TWO && dv_tag.sq) ? sat_root(qs2) : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, r2_q, r1_q, cnt_q};

	// absent roots read as zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cnt_q == qrs_pkg::CNT_NONE || cnt_q == qrs_pkg::CNT_ALL)
		|-> (r1_q == '0 && r2_q == '0)) else $error("roots present without a root");
	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cnt_q != qrs_pkg::CNT_TWO |-> r2_q == '0)
		else $error("second root present without two roots");
	a_back_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> en_b) else $error("back stalled with empty output");

endmodule

@@ sim/tb_quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Streams coefficient sets into the solver and checks every root item against
// an exact integer model of truncated real roots. A directed table covers the
// degenerate cases and the coefficient extremes; random sets follow, under
// several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;

	localparam int LATENCY   = 72;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 1830;

	typedef struct packed {
		logic [1:0]         cnt;
		logic signed [39:0] r1;
		logic signed [39:0] r2;
	} roots_t;

	typedef struct {
		logic signed [15:0] a, b, c;
		logic               known;
		roots_t             res;
	} vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;

	roots_t roots_due[$];
	int     n_bad = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;
	bit     hold_off = 1'b0;
	int     wdog = 0;

	quadratic_root_solver uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor square root of a non-negative value
	function automatic logic [63:0] isqrt(input logic [127:0] m);
		logic [63:0]  r;
		logic [63:0]  cand;
		r = '0;
		for (int i = 61; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			if (128'(cand) * 128'(cand) <= m)
				r = cand;
		end
		return r;
	endfunction

	// trunc((n + t) / d) with 0 < t < 1 when inexact
	function automatic longint trunc_div(input longint n, input bit inexact, input longint d);
		longint m;
		if (d < 0) begin
			n = inexact ? -n - 1 : -n;
			d = -d;
		end
		if (n >= 0)
			return n / d;
		m = inexact ? -(n + 1) : -n;
		return -(m / d);
	endfunction

	function automatic logic signed [39:0] clamp40(input longint v);
		if (v > 64'sd549755813887) v = 64'sd549755813887;
		if (v < -64'sd549755813888) v = -64'sd549755813888;
		return v[39:0];
	endfunction

	// exact truncated roots of a*x^2 + b*x + c
	function automatic roots_t solve_roots(input longint a, input longint b, input longint c);
		roots_t      r;
		longint      one, nb, r1, r2, pv, qv, dsc;
		logic [127:0] m;
		logic [63:0]  s;
		bit           inex;
		one = longint'(1) << qrs_pkg::FRAC_BITS;
		r1 = 0;
		r2 = 0;
		r.cnt = qrs_pkg::CNT_NONE;
		if (a == 0) begin
			if (b == 0)
				r.cnt = (c == 0) ? qrs_pkg::CNT_ALL : qrs_pkg::CNT_NONE;
			else begin
				r.cnt = qrs_pkg::CNT_ONE;
				r1 = trunc_div(-c * one, 1'b0, b);
			end
		end else if (b == 0) begin
			if (c == 0)
				r.cnt = qrs_pkg::CNT_ONE;
			else if ((a < 0) != (c < 0)) begin
				m = (128'(a < 0 ? -a : a) * 128'(c < 0 ? -c : c))
					<< (2 + 2 * qrs_pkg::FRAC_BITS);
				s = isqrt(m);
				inex = (128'(s) * 128'(s)) != m;
				r.cnt = qrs_pkg::CNT_TWO;
				r1 = trunc_div(longint'(s), inex, 2 * (a < 0 ? -a : a));
				r2 = -r1;
			end
		end else if (c == 0) begin
			r.cnt = qrs_pkg::CNT_TWO;
			r1 = trunc_div(-b * one, 1'b0, a);
		end else begin
			pv = b * b;
			qv = 4 * a * c;
			dsc = pv - qv;
			nb = -b * one;
			if (dsc == 0) begin
				r.cnt = qrs_pkg::CNT_ONE;
				r1 = trunc_div(nb, 1'b0, 2 * a);
			end else if (dsc > 0) begin
				m = 128'(dsc) << (2 * qrs_pkg::FRAC_BITS);
				s = isqrt(m);
				inex = (128'(s) * 128'(s)) != m;
				r.cnt = qrs_pkg::CNT_TWO;
				r1 = trunc_div(nb + longint'(s), inex, 2 * a);
				r2 = trunc_div(inex ? nb - longint'(s) - 1 : nb - longint'(s), inex, 2 * a);
			end
		end
		r.r1 = clamp40(r1);
		r.r2 = clamp40(r2);
		return r;
	endfunction

	// offer one coefficient set and wait for it to be taken
	task automatic send_coefs(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
			input bit known, input roots_t res);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {c, b, a};
		roots_due.push_back(known ? res :
			solve_roots(longint'($signed(a)), longint'($signed(b)), longint'($signed(c))));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// sender goes idle until every expected result has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (roots_due.size() > 0)
			@(posedge clk);
	endtask

	// receiver readiness, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		roots_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[1:0], m_tdata[41:2], m_tdata[81:42]};
			if (roots_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = roots_due.pop_front();
				if (got.cnt !== want.cnt || got.r1 !== want.r1 || got.r2 !== want.r2) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: exp cnt %0d r1 %0d r2 %0d, got cnt %0d r1 %0d r2 %0d",
							want.cnt, want.r1, want.r2, got.cnt, got.r1, got.r2);
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("tb_quadratic_root_solver: done, errors");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering
	task automatic long_hold();
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	endtask

	vec_t   dir[$];
	roots_t zr;

	function automatic vec_t mk(input int a, input int b, input int c, input bit known,
			input logic [1:0] cnt, input longint r1, input longint r2);
		vec_t v;
		v.a = 16'(a); v.b = 16'(b); v.c = 16'(c); v.known = known;
		v.res.cnt = cnt; v.res.r1 = 40'(r1); v.res.r2 = 40'(r2);
		return v;
	endfunction

	initial begin
		int    ph;
		int    sel;
		logic [15:0] ra, rb, rc;
		zr = '0;
		// directed table: special cases and extremes
		dir.push_back(mk(0, 0, 0, 1, qrs_pkg::CNT_ALL, 0, 0));
		dir.push_back(mk(0, 0, 5, 1, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(0, 0, -32768, 1, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(0, 2, -4, 1, qrs_pkg::CNT_ONE, 2 * 65536, 0));
		dir.push_back(mk(0, -32768, 32767, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(0, 1, -32768, 1, qrs_pkg::CNT_ONE, 32768 * 65536, 0));
		dir.push_back(mk(3, 0, 0, 1, qrs_pkg::CNT_ONE, 0, 0));
		dir.push_back(mk(1, 0, -4, 1, qrs_pkg::CNT_TWO, 2 * 65536, -2 * 65536));
		dir.push_back(mk(1, 0, 4, 1, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(-32768, 0, 32767, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(32767, 0, -32768, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(2, 6, 0, 1, qrs_pkg::CNT_TWO, -3 * 65536, 0));
		dir.push_back(mk(-32768, 32767, 0, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(1, -2, 1, 1, qrs_pkg::CNT_ONE, 65536, 0));
		dir.push_back(mk(1, -3, 2, 1, qrs_pkg::CNT_TWO, 2 * 65536, 65536));
		dir.push_back(mk(1, 1, 1, 1, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(-32768, -32768, -32768, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(32767, 32767, 32767, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(-32768, 32767, 32767, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(1, -32768, -32768, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(-1, 32767, 1, 0, qrs_pkg::CNT_NONE, 0, 0));
		dir.push_back(mk(7, 3, -5, 0, qrs_pkg::CNT_NONE, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i])
			send_coefs(dir[i].a, dir[i].b, dir[i].c, dir[i].known, dir[i].res);
		wait_drained();

		// random phases with different idling patterns
		for (ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 30 : 0;
			stall_pct = (ph == 2) ? 46 : (ph == 3) ? 30 : 0;
			if (ph == 2)
				fork
					long_hold();
				join_none
			for (int k = 0; k < N_RANDOM / 4; k++) begin
				sel = $urandom_range(9);
				ra = 16'($urandom); rb = 16'($urandom); rc = 16'($urandom);
				if (sel == 0) ra = '0;
				if (sel == 1) rb = '0;
				if (sel == 2) rc = '0;
				// small coefficients give double roots and exact roots more often
				if (sel >= 6) begin
					ra = 16'($urandom_range(0, 15) - 8);
					rb = 16'($urandom_range(0, 31) - 16);
					rc = 16'($urandom_range(0, 15) - 8);
				end
				send_coefs(ra, rb, rc, 1'b0, zr);
			end
			wait_drained();
		end
		idle_pct = 0;
		stall_pct = 0;

		repeat (LATENCY + 20) @(posedge clk);
		if (n_bad == 0 && roots_due.size() == 0)
			$display("tb_quadratic_root_solver: done, clean");
		else
			$display("tb_quadratic_root_solver: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_fifo.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
